@@ rtl/gcb_pkg.sv @@
// Shared types and constants for the glyph column bitmap blitter.
package gcb_pkg;

	localparam int CUR_W   = 11;
	localparam int POS_W   = 10;
	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 19;
	localparam int COLOR_W = 24;
	localparam int HGT_W   = 6;
	localparam int CNT_W   = 3;
	localparam int IDX_W   = 2;

	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	localparam logic [HGT_W-1:0]   HEIGHT_RST = 6'd16;
	localparam logic [COLOR_W-1:0] BACK_RST   = 24'hffffff;

	typedef enum logic [IDX_W-1:0] {
		REG_HEIGHT = 2'd0,
		REG_OPAQUE = 2'd1,
		REG_FORE   = 2'd2,
		REG_BACK   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [HGT_W-1:0]   height;
		logic               opaque;
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] back;
	} cfg_t;

	typedef struct packed {
		logic              is_start;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [BYTE_W-1:0] bits;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

@@ rtl/gcb_front.sv @@
// Front end: accepts input transactions, decodes them and queues them for the scan engine.
module gcb_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic [gcb_pkg::POS_W-1:0] start_x,
	input  logic [gcb_pkg::POS_W-1:0] start_y,
	input  logic [gcb_pkg::BYTE_W-1:0] font_byte,
	output gcb_pkg::queue_head_t      head,
	input  logic                      pop
);

	gcb_pkg::item_t slot_q [2];
	gcb_pkg::item_t item_in;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           do_pop;

	always_comb begin
		item_in.is_start = (opcode == gcb_pkg::OP_START);
		item_in.x        = start_x;
		item_in.y        = start_y;
		item_in.bits     = font_byte;
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid & in_ready;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];
	assign do_pop     = pop & head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= item_in;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count overflow");
	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !do_pop) |=> count_q == 2'd2) else $error("full queue lost entry");
	a_empty_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 && push) |=> count_q == 2'd1) else $error("push into empty queue lost");

endmodule

@@ rtl/gcb_back.sv @@
// Back end: glyph cursor, stallable bit-per-cycle column scan, pending and output registers.
module gcb_back #(
	parameter int SCREEN_WIDTH  = 800,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gcb_pkg::cfg_t               cfg,
	input  gcb_pkg::queue_head_t        head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gcb_pkg::ADDR_W-1:0]  pixel_addr,
	output logic [gcb_pkg::COLOR_W-1:0] pixel_color,
	output logic                        last
);

	localparam int CW  = gcb_pkg::CUR_W;
	localparam int PW  = 2 * CW;

	logic [CW-1:0]                 x_q, y_q;
	logic [gcb_pkg::POS_W-1:0]     top_q;
	logic                          halted_q;
	logic                          busy_q;
	logic [gcb_pkg::CNT_W-1:0]     cnt_q;
	logic [gcb_pkg::BYTE_W-1:0]    bits_q;
	logic                          pend_v_q, pend_last_q;
	logic [gcb_pkg::ADDR_W-1:0]    pend_addr_q;
	logic [gcb_pkg::COLOR_W-1:0]   pend_color_q;

	logic                          bit_set, paint, onscr, wr;
	logic [CW-1:0]                 y_inc, x_inc, dy;
	logic                          bottom, wrap, end_c;
	logic                          need, out_free, stall, step, out_load, emit_last;
	logic                          halted_nx;
	logic [PW-1:0]                 row_prod;
	logic [gcb_pkg::ADDR_W-1:0]    addr_c;

	always_comb begin
		bit_set   = bits_q[gcb_pkg::BYTE_W-1];
		paint     = bit_set | cfg.opaque;
		onscr     = (x_q < CW'(SCREEN_WIDTH)) && (y_q < CW'(SCREEN_HEIGHT));
		wr        = busy_q & paint & onscr;
		y_inc     = y_q + CW'(1);
		x_inc     = x_q + CW'(1);
		dy        = y_inc - {1'b0, top_q};
		bottom    = (y_inc >= CW'(SCREEN_HEIGHT));
		wrap      = (dy == CW'(cfg.height));
		end_c     = bottom | wrap | (cnt_q == gcb_pkg::CNT_W'(7));
		out_free  = ~out_valid | out_ready;
		need      = pend_v_q & (wr | (end_c & ~pend_last_q));
		stall     = need & ~out_free;
		step      = busy_q & ~stall;
		out_load  = out_free & pend_v_q & (pend_last_q | (step & (wr | end_c)));
		emit_last = pend_last_q | (end_c & ~wr);
		halted_nx = halted_q;
		if (step && bottom)
			halted_nx = 1'b1;
		else if (step && wrap && (x_inc >= CW'(SCREEN_WIDTH)))
			halted_nx = 1'b1;
		pop       = head.valid & (~busy_q | (step & end_c));
		row_prod  = PW'(y_q) * PW'(SCREEN_WIDTH);
		addr_c    = row_prod[gcb_pkg::ADDR_W-1:0] + gcb_pkg::ADDR_W'(x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			top_q       <= '0;
			halted_q    <= 1'b1;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_last_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (step) begin
				cnt_q <= cnt_q + gcb_pkg::CNT_W'(1);
				if (bottom) begin
					y_q <= y_inc;
				end else if (wrap) begin
					y_q <= {1'b0, top_q};
					x_q <= x_inc;
				end else begin
					y_q <= y_inc;
				end
				if (end_c)
					busy_q <= 1'b0;
			end
			halted_q <= halted_nx;
			if (pop) begin
				if (head.item.is_start) begin
					x_q      <= {1'b0, head.item.x};
					y_q      <= {1'b0, head.item.y};
					top_q    <= head.item.y;
					halted_q <= 1'b0;
					busy_q   <= 1'b0;
				end else if (!halted_nx) begin
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end
			if (step && wr) begin
				pend_v_q    <= 1'b1;
				pend_last_q <= end_c;
			end else if (out_load) begin
				pend_v_q <= 1'b0;
			end
			if (out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			bits_q <= bits_q << 1;
		if (pop && !head.item.is_start)
			bits_q <= head.item.bits;
		if (step && wr) begin
			pend_addr_q  <= addr_c;
			pend_color_q <= bit_set ? cfg.fore : cfg.back;
		end
		if (out_load) begin
			pixel_addr  <= pend_addr_q;
			pixel_color <= pend_color_q;
			last        <= emit_last;
		end
	end

	a_busy_active: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !halted_q) else $error("scanning while halted");
	a_open_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !pend_last_q) |-> busy_q) else $error("unfinished write outside a byte");
	a_eighth_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(step && cnt_q == gcb_pkg::CNT_W'(7)) |-> end_c) else $error("byte scan overran");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && stall) |=> busy_q && $stable(cnt_q) && $stable(y_q))
		else $error("scan advanced under stall");

endmodule

@@ rtl/glyph_column_bitmap_blitter.sv @@
// Top level of the glyph column bitmap blitter: configuration registers, front end and scan engine.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   opcode, start_x, start_y, font_byte
//   out       output     out_valid / out_ready pixel_addr, pixel_color, last
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// At most one pixel write per cycle unless the output stalls: a font byte holds the scan
// engine while it scans up to eight bits, until its column ends; a start only reloads the cursor.
// The next queued transaction is taken in the cycle a byte finishes.
// A two-entry queue decouples input acceptance from the scan engine.
// Reset clears the cursor, halts the glyph and loads the register defaults; no clearing pass.
// A stalled output holds the scan once the pending write cannot move forward.
module glyph_column_bitmap_blitter #(
	parameter int SCREEN_WIDTH  = 800,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gcb_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gcb_pkg::COLOR_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [gcb_pkg::POS_W-1:0]    start_x,
	input  logic [gcb_pkg::POS_W-1:0]    start_y,
	input  logic [gcb_pkg::BYTE_W-1:0]   font_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gcb_pkg::ADDR_W-1:0]   pixel_addr,
	output logic [gcb_pkg::COLOR_W-1:0]  pixel_color,
	output logic                         last
);

	gcb_pkg::cfg_t        cfg_q;
	gcb_pkg::queue_head_t head;
	logic                 pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height <= gcb_pkg::HEIGHT_RST;
			cfg_q.opaque <= 1'b0;
			cfg_q.fore   <= '0;
			cfg_q.back   <= gcb_pkg::BACK_RST;
		end else if (cfg_we) begin
			case (gcb_pkg::reg_idx_t'(cfg_index))
				gcb_pkg::REG_HEIGHT: cfg_q.height <= cfg_data[gcb_pkg::HGT_W-1:0];
				gcb_pkg::REG_OPAQUE: cfg_q.opaque <= cfg_data[0];
				gcb_pkg::REG_FORE:   cfg_q.fore   <= cfg_data;
				gcb_pkg::REG_BACK:   cfg_q.back   <= cfg_data;
				default:             cfg_q        <= cfg_q;
			endcase
		end
	end

	gcb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.start_x   (start_x),
		.start_y   (start_y),
		.font_byte (font_byte),
		.head      (head),
		.pop       (pop)
	);

	gcb_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_addr  (pixel_addr),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule
